// ===== hw/rtl/hfp_pkg.sv =====
// ----------------------------------------------------------------------------
// hfp_pkg
// Shared types and constants of the hmm forward probability block.
// ----------------------------------------------------------------------------
package hfp_pkg;

  localparam int MAX_STATES_DEF  = 16;
  localparam int MAX_LETTERS_DEF = 256;
  localparam int PROB_BITS_DEF   = 32;

  localparam logic [1:0] OP_WR_TRANS = 2'd0;
  localparam logic [1:0] OP_WR_EMIT  = 2'd1;
  localparam logic [1:0] OP_START    = 2'd2;
  localparam logic [1:0] OP_SYMBOL   = 2'd3;

  localparam logic [1:0] CFG_STATES  = 2'd0;
  localparam logic [1:0] CFG_LETTERS = 2'd1;
  localparam logic [1:0] CFG_INITIAL = 2'd2;
  localparam logic [1:0] CFG_FINAL   = 2'd3;

  localparam logic [31:0] Q31_ONE = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  row_state;
    logic [7:0]  column;
    logic [31:0] table_value;
    logic [7:0]  symbol;
  } in_t;

  typedef struct packed {
    logic [31:0] end_probability;
    logic [15:0] symbols_seen;
    logic        bad_symbol;
  } out_t;

  // controls shared by every cell of the forward ring
  typedef struct packed {
    logic start;
    logic rotate;
    logic push;
    logic load;
  } cell_ctrl_t;

  // tag carried with each term through the multiply pipeline
  typedef struct packed {
    logic first;
    logic last;
    logic gate;
    logic final_term;
  } mac_tag_t;

endpackage

// ===== hw/rtl/hmm_forward_probability.sv =====
// ----------------------------------------------------------------------------
// hmm_forward_probability
// Hidden markov model forward pass over a ring of forward vector cells.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_stall/in_data. A transfer is taken at a
// clock edge with in_valid high and in_stall low. Table writes and start
// items give no result. A symbol item gives one result on
// out_valid/out_stall/out_data.
// A good symbol issues all MAX_STATES*MAX_STATES terms through one shared
// multiply pipeline (the forward ring rotates once per next state); then the
// pipeline drains, the new forward vector is loaded and the result is
// registered. A rejected symbol goes straight to the done state, and its
// result is registered from there.
// in_stall is high while a symbol is worked on; one item at a time.
// The result waits in an output register while out_stall is high; the next
// item is taken meanwhile, and a new result waits until the old one leaves.
// Reset (rst, synchronous) sets the configuration registers to their
// defaults, the forward vector one-hot at state 0 and the counter to zero.
// Table memories are not cleared and must be written before use.
// Configuration writes (cfg_write) are taken at any edge.
// ----------------------------------------------------------------------------
module hmm_forward_probability #(
  parameter int MAX_STATES  = hfp_pkg::MAX_STATES_DEF,
  parameter int MAX_LETTERS = hfp_pkg::MAX_LETTERS_DEF,
  parameter int PROB_BITS   = hfp_pkg::PROB_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hfp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hfp_pkg::out_t out_data,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [8:0]    cfg_data
);

  localparam int IW  = $clog2(MAX_STATES);
  localparam int NW  = $clog2(MAX_STATES + 1);
  localparam int LW  = $clog2(MAX_LETTERS + 1);
  localparam int TD  = MAX_STATES * MAX_STATES;
  localparam int ED  = MAX_STATES * MAX_LETTERS;
  localparam int TAW = $clog2(TD);
  localparam int EAW = $clog2(ED);
  localparam int XW  = PROB_BITS + 32;
  localparam int UP  = (PROB_BITS >= 32) ? PROB_BITS - 32 : 0;
  localparam int DN  = (PROB_BITS >= 32) ? 0 : 32 - PROB_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]  state, state_next;
  logic [4:0]  states_in_use;
  logic [8:0]  letters_in_use;
  logic [3:0]  initial_state, final_state;
  logic [IW-1:0] i_cnt, j_cnt;
  logic [7:0]  sym;
  logic        bad;
  logic [15:0] symbol_counter;
  logic [NW-1:0] n_eff;
  logic [LW-1:0] letters_eff;

  logic in_xfer, out_xfer, out_free, issue;
  logic i_last, j_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      states_in_use  <= 5'd16;
      letters_in_use <= 9'd256;
      initial_state  <= 4'd0;
      final_state    <= 4'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hfp_pkg::CFG_STATES:  states_in_use  <= cfg_data[4:0];
        hfp_pkg::CFG_LETTERS: letters_in_use <= cfg_data;
        hfp_pkg::CFG_INITIAL: initial_state  <= cfg_data[3:0];
        hfp_pkg::CFG_FINAL:   final_state    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (32'(states_in_use) > 32'(MAX_STATES)) ? NW'(MAX_STATES)
                                                         : NW'(states_in_use);
  assign letters_eff = (32'(letters_in_use) > 32'(MAX_LETTERS)) ? LW'(MAX_LETTERS)
                                                                 : LW'(letters_in_use);

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;

  // table writes, values clamped to one and moved into the internal format
  logic [31:0]          val_clamped;
  logic [XW-1:0]        val_ext;
  logic [PROB_BITS-1:0] val_int;
  logic                 tr_we, em_we;
  logic [TAW-1:0]       tr_waddr, tr_raddr;
  logic [EAW-1:0]       em_waddr, em_raddr;
  logic [PROB_BITS-1:0] tr_rdata, em_rdata;

  assign val_clamped = (in_data.table_value > hfp_pkg::Q31_ONE) ? hfp_pkg::Q31_ONE
                                                                : in_data.table_value;
  assign val_ext = ((XW'(val_clamped)) << UP) >> DN;
  assign val_int = val_ext[PROB_BITS-1:0];

  assign tr_we = in_xfer && (in_data.op == hfp_pkg::OP_WR_TRANS)
                 && (32'(in_data.row_state) < 32'(MAX_STATES))
                 && (32'(in_data.column) < 32'(MAX_STATES));
  assign em_we = in_xfer && (in_data.op == hfp_pkg::OP_WR_EMIT)
                 && (32'(in_data.row_state) < 32'(MAX_STATES))
                 && (32'(in_data.column) < 32'(MAX_LETTERS));
  assign tr_waddr = TAW'(32'(in_data.row_state) * MAX_STATES + 32'(in_data.column));
  assign em_waddr = EAW'(32'(in_data.row_state) * MAX_LETTERS + 32'(in_data.column));
  assign tr_raddr = TAW'(32'(i_cnt) * MAX_STATES + 32'(j_cnt));
  assign em_raddr = EAW'(32'(j_cnt) * MAX_LETTERS + 32'(sym));

  hfp_ram #(.WIDTH(PROB_BITS), .DEPTH(TD)) u_trans (
    .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(val_int),
    .raddr(tr_raddr), .rdata(tr_rdata)
  );

  hfp_ram #(.WIDTH(PROB_BITS), .DEPTH(ED)) u_emit (
    .clk(clk), .we(em_we), .waddr(em_waddr), .wdata(val_int),
    .raddr(em_raddr), .rdata(em_rdata)
  );

  // sequencer
  logic push, push_final;
  logic [PROB_BITS-1:0] push_value;

  assign i_last = (i_cnt == IW'(MAX_STATES - 1));
  assign j_last = (j_cnt == IW'(MAX_STATES - 1));
  assign issue  = (state == ST_RUN);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && in_data.op == hfp_pkg::OP_SYMBOL) begin
          state_next = (32'(in_data.symbol) < 32'(letters_eff)) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN:   if (i_last && j_last) state_next = ST_DRAIN;
      ST_DRAIN: if (push_final) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
    end else begin
      state <= state_next;
      if (issue) begin
        i_cnt <= i_last ? '0 : i_cnt + IW'(1);
        if (i_last) begin
          j_cnt <= j_last ? '0 : j_cnt + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.op == hfp_pkg::OP_SYMBOL) begin
      sym <= in_data.symbol;
      bad <= !(32'(in_data.symbol) < 32'(letters_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_counter <= '0;
    end else if (in_xfer && in_data.op == hfp_pkg::OP_START) begin
      symbol_counter <= '0;
    end else if (state == ST_LOAD && symbol_counter != 16'hFFFF) begin
      symbol_counter <= symbol_counter + 16'd1;
    end
  end

  // forward ring: cell 0 is the head that feeds the multiply pipeline
  hfp_pkg::cell_ctrl_t  ctrl;
  hfp_pkg::mac_tag_t    tag;
  logic [PROB_BITS-1:0] fwd [MAX_STATES];
  logic [PROB_BITS-1:0] nxt [MAX_STATES];

  assign ctrl.start  = in_xfer && (in_data.op == hfp_pkg::OP_START);
  assign ctrl.rotate = issue;
  assign ctrl.push   = push;
  assign ctrl.load   = (state == ST_LOAD);

  for (genvar k = 0; k < MAX_STATES; k++) begin : g_cell
    logic init_one;
    assign init_one = (32'(initial_state) < 32'(MAX_STATES))
                      && (IW'(initial_state) == IW'(k));
    hfp_cell #(.PROB_BITS(PROB_BITS)) u_cell (
      .clk(clk), .rst(rst), .ctrl(ctrl),
      .init_one(init_one), .reset_one(k == 0),
      .fwd_in(fwd[(k + 1) % MAX_STATES]),
      .nxt_in((k == MAX_STATES - 1) ? push_value : nxt[(k + 1) % MAX_STATES]),
      .fwd(fwd[k]), .nxt(nxt[k])
    );
  end

  assign tag.first      = (i_cnt == '0);
  assign tag.last       = i_last;
  assign tag.gate       = (32'(i_cnt) < 32'(n_eff)) && (32'(j_cnt) < 32'(n_eff));
  assign tag.final_term = i_last && j_last;

  hfp_mac #(.PROB_BITS(PROB_BITS)) u_mac (
    .clk(clk), .rst(rst), .issue(issue), .issue_tag(tag),
    .fwd_val(fwd[0]), .trans_val(tr_rdata), .emit_val(em_rdata),
    .push(push), .push_final(push_final), .push_value(push_value)
  );

  // result register
  logic [PROB_BITS-1:0] fin_val;
  logic [XW-1:0]        fin_ext;

  assign fin_val = (32'(final_state) < 32'(MAX_STATES)) ? fwd[IW'(final_state)] : '0;
  assign fin_ext = ((XW'(fin_val)) >> UP) << DN;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_data.end_probability <= fin_ext[31:0];
      out_data.symbols_seen    <= symbol_counter;
      out_data.bad_symbol      <= bad;
    end
  end

endmodule

// ===== hw/rtl/hfp_ram.sv =====
// ----------------------------------------------------------------------------
// hfp_ram
// Generic simple dual port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module hfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/hfp_cell.sv =====
// ----------------------------------------------------------------------------
// hfp_cell
// One forward vector cell: a rotating forward value and a shifting next value.
// ----------------------------------------------------------------------------
module hfp_cell #(
  parameter int PROB_BITS = hfp_pkg::PROB_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hfp_pkg::cell_ctrl_t    ctrl,
  input  logic                   init_one,
  input  logic                   reset_one,
  input  logic [PROB_BITS-1:0]   fwd_in,
  input  logic [PROB_BITS-1:0]   nxt_in,
  output logic [PROB_BITS-1:0]   fwd,
  output logic [PROB_BITS-1:0]   nxt
);

  localparam logic [PROB_BITS-1:0] ONE = PROB_BITS'(1) << (PROB_BITS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= reset_one ? ONE : '0;
    end else if (ctrl.start) begin
      fwd <= init_one ? ONE : '0;
    end else if (ctrl.load) begin
      fwd <= nxt;
    end else if (ctrl.rotate) begin
      fwd <= fwd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      nxt <= nxt_in;
    end
  end

endmodule

// ===== hw/rtl/hfp_mac.sv =====
// ----------------------------------------------------------------------------
// hfp_mac
// Shared multiply pipeline: forward times transition times emission, summed.
// ----------------------------------------------------------------------------
module hfp_mac #(
  parameter int PROB_BITS = hfp_pkg::PROB_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 issue,
  input  hfp_pkg::mac_tag_t    issue_tag,
  input  logic [PROB_BITS-1:0] fwd_val,
  input  logic [PROB_BITS-1:0] trans_val,
  input  logic [PROB_BITS-1:0] emit_val,
  output logic                 push,
  output logic                 push_final,
  output logic [PROB_BITS-1:0] push_value
);

  localparam logic [PROB_BITS:0] ONE_EXT = (PROB_BITS + 1)'(1) << (PROB_BITS - 1);
  localparam logic [PROB_BITS-1:0] ONE = PROB_BITS'(1) << (PROB_BITS - 1);

  logic                   va, vb, vc;
  hfp_pkg::mac_tag_t      tag_a, tag_b, tag_c;
  logic [PROB_BITS-1:0]   f_a, e_b, p1_b, p2_c, acc;
  logic [2*PROB_BITS-1:0] prod1, prod2;
  logic [PROB_BITS:0]     sh1, sh2, sum;
  logic [PROB_BITS-1:0]   p1, p2, acc_in, term, sum_sat;

  // stage a lines the forward value up with the ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= issue;
      vb <= va;
      vc <= vb;
    end
  end

  assign prod1 = (2*PROB_BITS)'(f_a) * (2*PROB_BITS)'(trans_val);
  assign sh1   = prod1[2*PROB_BITS-1:PROB_BITS-1];
  assign p1    = (sh1 > ONE_EXT) ? ONE : sh1[PROB_BITS-1:0];

  assign prod2 = (2*PROB_BITS)'(p1_b) * (2*PROB_BITS)'(e_b);
  assign sh2   = prod2[2*PROB_BITS-1:PROB_BITS-1];
  assign p2    = (sh2 > ONE_EXT) ? ONE : sh2[PROB_BITS-1:0];

  always_ff @(posedge clk) begin
    f_a   <= fwd_val;
    tag_a <= issue_tag;
    p1_b  <= p1;
    e_b   <= emit_val;
    tag_b <= tag_a;
    p2_c  <= p2;
    tag_c <= tag_b;
  end

  // saturating accumulate, restarted at the first term of each column
  assign acc_in  = tag_c.first ? '0 : acc;
  assign term    = tag_c.gate ? p2_c : '0;
  assign sum     = (PROB_BITS + 1)'(acc_in) + (PROB_BITS + 1)'(term);
  assign sum_sat = (sum > ONE_EXT) ? ONE : sum[PROB_BITS-1:0];

  always_ff @(posedge clk) begin
    if (vc) begin
      acc <= sum_sat;
    end
  end

  assign push       = vc && tag_c.last;
  assign push_final = vc && tag_c.final_term;
  assign push_value = sum_sat;

endmodule

// ===== hw/rtl/hfp_checker.sv =====
// ----------------------------------------------------------------------------
// hfp_checker
// Port level checks of the hmm forward probability block.
// ----------------------------------------------------------------------------
module hfp_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input hfp_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input hfp_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // ready for input right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");

  // a symbol transfer occupies the block
  a_symbol_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.op == hfp_pkg::OP_SYMBOL |=> in_stall)
    else $error("block took input while working on a symbol");

  // probability never exceeds one
  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.end_probability <= hfp_pkg::Q31_ONE)
    else $error("end probability above one");

endmodule

bind hmm_forward_probability hfp_checker u_hfp_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== tb/hmm_forward_probability_tb.sv =====
// ----------------------------------------------------------------------------
// hmm_forward_probability_tb
// Self-checking bench for the hmm forward pass: fills the tables, runs
// directed and random item streams over several register settings with random
// idling on both channels, and checks every result against a cycle-free model.
// ----------------------------------------------------------------------------
module hmm_forward_probability_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NS         = 16;
  localparam int NL         = 256;
  localparam int DRAIN      = 300;
  localparam int CYCLE_CAP  = 3000000;

  class forward_checker;
    logic [31:0]   trans[NS*NS];
    logic [31:0]   emit[NS*NL];
    bit            emit_known[NS*NL];
    logic [31:0]   fwd[NS];
    logic [15:0]   seen;
    logic [4:0]    n_states;
    logic [8:0]    n_letters;
    logic [3:0]    init_st;
    logic [3:0]    fin_st;
    hfp_pkg::out_t pending_results[$];
    int            mismatches;

    function new();
      foreach (trans[k]) trans[k] = '0;
      foreach (emit[k]) begin
        emit[k] = '0;
        emit_known[k] = 0;
      end
      n_states = 5'd16;
      n_letters = 9'd256;
      init_st = 4'd0;
      fin_st = 4'd1;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      foreach (fwd[k]) fwd[k] = '0;
      fwd[init_st] = hfp_pkg::Q31_ONE;
      seen = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] value);
      case (idx)
        hfp_pkg::CFG_STATES:  n_states = value[4:0];
        hfp_pkg::CFG_LETTERS: n_letters = value;
        hfp_pkg::CFG_INITIAL: init_st = value[3:0];
        hfp_pkg::CFG_FINAL:   fin_st = value[3:0];
        default: ;
      endcase
    endfunction

    function int eff_states();
      return (n_states < NS) ? int'(n_states) : NS;
    endfunction

    function int eff_letters();
      return (n_letters < NL) ? int'(n_letters) : NL;
    endfunction

    // a symbol may only read emission entries that have been written
    function bit symbol_safe(int sym);
      if (sym >= eff_letters()) return 1;
      for (int j = 0; j < eff_states(); j++)
        if (!emit_known[j*NL + sym]) return 0;
      return 1;
    endfunction

    function logic [31:0] qmul(logic [31:0] a, logic [31:0] b);
      logic [63:0] p;
      p = ({32'd0, a} * {32'd0, b}) >> 31;
      return (p > 64'(hfp_pkg::Q31_ONE)) ? hfp_pkg::Q31_ONE : p[31:0];
    endfunction

    function logic [31:0] clamp_one(logic [31:0] v);
      return (v > hfp_pkg::Q31_ONE) ? hfp_pkg::Q31_ONE : v;
    endfunction

    function void note_input(hfp_pkg::in_t it);
      logic [31:0] nxt[NS];
      logic [63:0] acc;
      logic [31:0] e;
      hfp_pkg::out_t r;
      int n;
      int sym;
      case (it.op)
        hfp_pkg::OP_WR_TRANS: begin
          if (it.column < NS) trans[it.row_state*NS + it.column] = clamp_one(it.table_value);
        end
        hfp_pkg::OP_WR_EMIT: begin
          emit[it.row_state*NL + it.column] = clamp_one(it.table_value);
          emit_known[it.row_state*NL + it.column] = 1;
        end
        hfp_pkg::OP_START: restart();
        default: begin
          n = eff_states();
          sym = it.symbol;
          r.bad_symbol = !(sym < eff_letters());
          if (!r.bad_symbol) begin
            foreach (nxt[k]) nxt[k] = '0;
            for (int j = 0; j < n; j++) begin
              e = emit[j*NL + sym];
              acc = '0;
              for (int i = 0; i < n; i++) begin
                acc += qmul(qmul(fwd[i], trans[i*NS + j]), e);
                if (acc > 64'(hfp_pkg::Q31_ONE)) acc = 64'(hfp_pkg::Q31_ONE);
              end
              nxt[j] = acc[31:0];
            end
            fwd = nxt;
            if (seen != 16'hFFFF) seen++;
          end
          r.end_probability = fwd[fin_st];
          r.symbols_seen = seen;
          pending_results.insert(pending_results.size(), r);
        end
      endcase
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch %s got %h want %h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(hfp_pkg::out_t got);
      hfp_pkg::out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", got.end_probability, '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.end_probability !== want.end_probability)
        report_mismatch("end_probability", got.end_probability, want.end_probability);
      if (got.symbols_seen !== want.symbols_seen)
        report_mismatch("symbols_seen", 32'(got.symbols_seen), 32'(want.symbols_seen));
      if (got.bad_symbol !== want.bad_symbol)
        report_mismatch("bad_symbol", 32'(got.bad_symbol), 32'(want.bad_symbol));
    endtask
  endclass

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  hfp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  hfp_pkg::out_t out_data;
  logic          cfg_write;
  logic [1:0]    cfg_index;
  logic [8:0]    cfg_data;

  forward_checker chk;
  bit             idling;
  int             cycles;

  hmm_forward_probability u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: sample at the rising edge, change stall at the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) chk.check_result(out_data);
      @(negedge clk);
      out_stall = idling && ($urandom_range(99) < 37);
    end
  end

  function logic [31:0] rand_prob();
    case ($urandom_range(9))
      0, 1:    return hfp_pkg::Q31_ONE;
      2:       return '0;
      3:       return $urandom;
      4:       return 32'hFFFF_FFFF;
      5:       return hfp_pkg::Q31_ONE + 32'd1;
      default: return hfp_pkg::Q31_ONE - $urandom_range(0, 32'h0800_0000);
    endcase
  endfunction

  function hfp_pkg::in_t rand_item(logic [1:0] op);
    hfp_pkg::in_t it;
    it.op = op;
    it.row_state = 4'($urandom_range(15));
    it.column = 8'($urandom_range(255));
    it.table_value = rand_prob();
    it.symbol = 8'($urandom_range(255));
    return it;
  endfunction

  // entered and left at a falling edge; valid stays high into the next call
  task send_item(hfp_pkg::in_t it);
    while (idling && ($urandom_range(99) < 37)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    chk.note_input(it);
    @(negedge clk);
  endtask

  task send_table(logic [1:0] op, int row, int col, logic [31:0] value);
    hfp_pkg::in_t it;
    it = rand_item(op);
    it.row_state = 4'(row);
    it.column = 8'(col);
    it.table_value = value;
    send_item(it);
  endtask

  task send_symbol(int sym);
    hfp_pkg::in_t it;
    it = rand_item(hfp_pkg::OP_SYMBOL);
    it.symbol = 8'(sym);
    send_item(it);
  endtask

  task settle();
    in_valid = 1'b0;
    while (chk.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [8:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    chk.set_reg(idx, value);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task set_all(int states, int letters, int init_s, int fin_s);
    settle();
    write_reg(hfp_pkg::CFG_STATES, 9'(states));
    write_reg(hfp_pkg::CFG_LETTERS, 9'(letters));
    write_reg(hfp_pkg::CFG_INITIAL, 9'(init_s));
    write_reg(hfp_pkg::CFG_FINAL, 9'(fin_s));
  endtask

  task random_items(int count);
    int r;
    int sym;
    hfp_pkg::in_t it;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        sym = $urandom_range(255);
        if (!chk.symbol_safe(sym)) begin
          sym = $urandom_range(3);
          if (sym >= 2) sym += 252;
        end
        send_symbol(sym);
      end else if (r < 65) begin
        send_item(rand_item(hfp_pkg::OP_WR_EMIT));
      end else if (r < 82) begin
        it = rand_item(hfp_pkg::OP_WR_TRANS);
        if ($urandom_range(3) != 0) it.column = 8'($urandom_range(15));
        send_item(it);
      end else begin
        send_item(rand_item(hfp_pkg::OP_START));
      end
    end
  endtask

  initial begin
    chk = new();
    cycles = 0;
    idling = 1;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill every transition entry and the emission columns symbols fall back on
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++)
        send_table(hfp_pkg::OP_WR_TRANS, i, j, rand_prob());
    for (int i = 0; i < NS; i++)
      for (int c = 0; c < 4; c++)
        send_table(hfp_pkg::OP_WR_EMIT, i, (c < 2) ? c : c + 252, rand_prob());

    // directed
    send_symbol(0);
    send_symbol(255);
    send_table(hfp_pkg::OP_WR_TRANS, 3, 200, 32'h1234_5678);
    send_table(hfp_pkg::OP_WR_TRANS, 15, 255, hfp_pkg::Q31_ONE);
    send_table(hfp_pkg::OP_WR_EMIT, 0, 0, 32'hFFFF_FFFF);
    send_table(hfp_pkg::OP_WR_EMIT, 15, 255, '0);
    send_table(hfp_pkg::OP_WR_TRANS, 0, 1, hfp_pkg::Q31_ONE);
    send_table(hfp_pkg::OP_WR_TRANS, 0, 0, hfp_pkg::Q31_ONE);
    send_table(hfp_pkg::OP_WR_EMIT, 1, 0, hfp_pkg::Q31_ONE);
    send_symbol(0);
    send_symbol(0);
    send_symbol(1);
    send_table(hfp_pkg::OP_WR_TRANS, 1, 1, 32'h0000_0001);
    send_symbol(254);
    send_item(rand_item(hfp_pkg::OP_START));
    send_symbol(255);
    send_symbol(1);
    send_item(rand_item(hfp_pkg::OP_START));
    send_symbol(0);

    set_all(16, 256, 15, 0);
    random_items(20);
    set_all(2, 1, 0, 15);
    random_items(20);
    idling = 0;
    set_all(31, 300, 7, 3);
    random_items(20);
    idling = 1;
    set_all(1, 0, 5, 5);
    random_items(15);
    set_all($urandom_range(2, 16), $urandom_range(1, 256), $urandom_range(15),
            $urandom_range(15));
    random_items(18);
    set_all($urandom_range(2, 16), 511, $urandom_range(15), $urandom_range(15));
    random_items(18);

    settle();
    if (chk.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== hmm_forward_probability.f =====
hw/rtl/hfp_pkg.sv
hw/rtl/hfp_ram.sv
hw/rtl/hfp_cell.sv
hw/rtl/hfp_mac.sv
hw/rtl/hmm_forward_probability.sv
hw/rtl/hfp_checker.sv
tb/hmm_forward_probability_tb.sv
